// File: rtl/bale_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bale_pkg
// Shared codes and the command beat passed from the front end to the back end
// of the bounded array list engine.
// ============================================================================
package bale_pkg;

  // request codes
  localparam logic [2:0] REQ_SET    = 3'd0;
  localparam logic [2:0] REQ_GET    = 3'd1;
  localparam logic [2:0] REQ_FIND   = 3'd2;
  localparam logic [2:0] REQ_INSERT = 3'd3;
  localparam logic [2:0] REQ_REMOVE = 3'd4;
  localparam logic [2:0] REQ_CLEAR  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // back end operations
  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_INSERT = 3'd4;
  localparam logic [2:0] CMD_REMOVE = 3'd5;

  // -1 in the 7-bit found index
  localparam logic [6:0] NONE_INDEX = 7'h7F;

  // sized for the largest supported capacity (4096 entries)
  localparam int ADDR_W = 12;
  localparam int CNT_W  = 13;

  localparam int CMDQ_DEPTH = 2;

  typedef struct packed {
    logic [2:0]        op;
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;   // write/read address, or shift start
    logic [CNT_W-1:0]  stop;   // shift end, or find limit
    logic [63:0]       value;
    logic [6:0]        total;  // entry count after the request, mod 128
  } cmd_t;

endpackage

// File: rtl/bale_front.sv
`timescale 1ns / 1ps
// ============================================================================
// bale_front
// Accepts requests, tracks the entry count and turns each request into a
// checked command with its status and final count already settled.
// ============================================================================
module bale_front import bale_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [2:0]  req_type,
  input  logic [5:0]  index,
  input  logic [63:0] value,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + CNT_W;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [EW-1:0]   idx_e;
  logic [EW-1:0]   cnt_e;
  logic [EW-1:0]   last_e;
  logic [CW+6:0]   tot_wide;

  assign q_push = push && !q_full;
  assign idx_e  = EW'(index);
  assign cnt_e  = EW'(count);
  assign last_e = cnt_e - 1'b1;

  always_comb begin
    q_cmd.op     = CMD_NONE;
    q_cmd.status = ST_OK;
    q_cmd.addr   = '0;
    q_cmd.stop   = '0;
    q_cmd.value  = value;
    count_next   = count;
    unique case (req_type)
      REQ_SET: begin
        if (idx_e < cnt_e) begin
          q_cmd.op   = CMD_WRITE;
          q_cmd.addr = idx_e[ADDR_W-1:0];
        end else begin
          q_cmd.status = ST_RANGE;
        end
      end
      REQ_GET: begin
        if (count == '0) begin
          q_cmd.status = ST_EMPTY;
        end else if (idx_e < cnt_e) begin
          q_cmd.op   = CMD_READ;
          q_cmd.addr = idx_e[ADDR_W-1:0];
        end else begin
          // past the end: hand back the last entry
          q_cmd.op     = CMD_READ;
          q_cmd.addr   = last_e[ADDR_W-1:0];
          q_cmd.status = ST_RANGE;
        end
      end
      REQ_FIND: begin
        q_cmd.op   = CMD_FIND;
        q_cmd.stop = cnt_e[CNT_W-1:0];
      end
      REQ_INSERT: begin
        if (cnt_e == EW'(CAPACITY)) begin
          q_cmd.status = ST_FULL;
        end else if (idx_e > cnt_e) begin
          q_cmd.status = ST_RANGE;
        end else begin
          q_cmd.op   = CMD_INSERT;
          q_cmd.addr = cnt_e[ADDR_W-1:0];
          q_cmd.stop = idx_e[CNT_W-1:0];
          count_next = count + 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (count == '0) begin
          q_cmd.status = ST_EMPTY;
        end else if (idx_e >= cnt_e) begin
          q_cmd.status = ST_RANGE;
        end else begin
          q_cmd.op   = CMD_REMOVE;
          q_cmd.addr = idx_e[ADDR_W-1:0];
          q_cmd.stop = last_e[CNT_W-1:0];
          count_next = count - 1'b1;
        end
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
      end
    endcase
    tot_wide    = {7'd0, count_next};
    q_cmd.total = tot_wide[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (q_push) begin
      count <= count_next;
    end
  end

endmodule

// File: rtl/bale_cmd_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// bale_cmd_fifo
// Short command queue between the front end and the back end.
// ============================================================================
module bale_cmd_fifo import bale_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic valid
);

  localparam int PW = $clog2(CMDQ_DEPTH);

  cmd_t          slots [CMDQ_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   fill;
  logic          do_push;
  logic          do_pop;

  assign full    = (fill == (PW+1)'(CMDQ_DEPTH));
  assign valid   = (fill != '0);
  assign dout    = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/bale_back.sv
`timescale 1ns / 1ps
// ============================================================================
// bale_back
// Carries out commands on the entry memory: single writes and reads, a linear
// search, and one-entry-per-cycle shifts for insert and remove. Holds the
// result beat until the receiver takes it.
// ============================================================================
module bale_back import bale_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  cmd_t               cmd,
  output logic               cmd_pop,
  input  logic               pop,
  output logic               empty,
  output logic [63:0]        read_value,
  output logic signed [6:0]  found_index,
  output logic [6:0]         item_total,
  output logic [1:0]         status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [63:0]   mem [CAPACITY];
  logic [63:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;

  logic [2:0]    state;
  logic [2:0]    op;
  logic [63:0]   val;
  logic [CW-1:0] stop;
  logic [CW-1:0] ptr;
  logic [AW-1:0] ptr_a;
  logic [AW-1:0] stop_a;
  logic          shift_more;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic          chk_valid;
  logic [AW-1:0] chk_pos;
  logic [AW+6:0] pos_wide;
  logic          res_free;

  logic [63:0]   res_value;
  logic [6:0]    res_found;
  logic [6:0]    res_total;
  logic [1:0]    res_status;
  logic          out_valid;

  assign ptr_a      = ptr[AW-1:0];
  assign stop_a     = stop[AW-1:0];
  assign shift_more = (ptr_a != stop_a);
  assign pos_wide   = {7'd0, chk_pos};
  assign res_free   = !out_valid || pop;
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;
  assign empty      = !out_valid;

  // memory port control
  always_comb begin
    rd_addr = cmd.addr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = cmd.addr[AW-1:0];
    wr_data = cmd.value;
    unique case (state)
      S_IDLE: begin
        if (cmd_pop && cmd.op == CMD_WRITE) begin
          wr_en = 1'b1;
        end
      end
      S_FIND: begin
        rd_addr = ptr_a;
      end
      S_SHIFT: begin
        // source is one below the target for insert, one above for remove
        rd_addr = (op == CMD_INSERT) ? ptr_a - 1'b1 : ptr_a + 1'b1;
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr;
          wr_data = rd_data;
        end else if (!shift_more && op == CMD_INSERT) begin
          wr_en   = 1'b1;
          wr_addr = ptr_a;
          wr_data = val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      // in S_DONE a leaving beat is replaced by the next one below
      if (out_valid && pop && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            op         <= cmd.op;
            val        <= cmd.value;
            stop       <= cmd.stop[CW-1:0];
            ptr        <= CW'(cmd.addr);
            res_value  <= '0;
            res_found  <= NONE_INDEX;
            res_total  <= cmd.total;
            res_status <= cmd.status;
            pend       <= 1'b0;
            chk_valid  <= 1'b0;
            unique case (cmd.op)
              CMD_READ: begin
                state <= S_READ;
              end
              CMD_FIND: begin
                ptr   <= '0;
                state <= S_FIND;
              end
              CMD_INSERT, CMD_REMOVE: begin
                state <= S_SHIFT;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          res_value <= rd_data;
          state     <= S_DONE;
        end
        S_FIND: begin
          // rd_data holds the entry at chk_pos, read last cycle
          if (chk_valid && rd_data == val) begin
            res_found <= pos_wide[6:0];
            chk_valid <= 1'b0;
            state     <= S_DONE;
          end else if (ptr == stop) begin
            chk_valid <= 1'b0;
            state     <= S_DONE;
          end else begin
            chk_valid <= 1'b1;
            chk_pos   <= ptr_a;
            ptr       <= ptr + 1'b1;
          end
        end
        S_SHIFT: begin
          if (shift_more) begin
            pend      <= 1'b1;
            pend_addr <= ptr_a;
            ptr       <= (op == CMD_INSERT) ? ptr - 1'b1 : ptr + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (res_free) begin
            out_valid   <= 1'b1;
            read_value  <= res_value;
            found_index <= res_found;
            item_total  <= res_total;
            status      <= res_status;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/bounded_array_list_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// bounded_array_list_engine
// Ordered list of up to CAPACITY 64-bit words with set, get, find, insert,
// remove and clear requests; one result beat per request.
// ============================================================================
// Usage:
//   Requests enter as a queue: a beat is taken when push is high and full is
//   low. Results leave as a queue: while empty is low the oldest result is on
//   read_value/found_index/item_total/status, and pop takes it.
//   The front end checks each request against the entry count and settles
//   status and item_total at once; a two-entry command queue feeds the back
//   end, which owns the entry memory with its one read and one write port.
//   With the back end idle, set, clear and rejected requests finish soonest;
//   insert and removes other than of the last entry take longer the more
//   entries lie between index and the end, and find takes longer the later
//   the match lies, or the longer the list is on a miss. The back end works
//   on one request at a time.
//   While the receiver stalls, the finished result is held, the back end
//   waits with the next one, and the front end keeps taking requests until
//   the command queue fills.
//   Reset (rst, synchronous) empties the list and both queues; memory
//   contents are not cleared and no unwritten entry is ever used.
// ============================================================================
module bounded_array_list_engine import bale_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         req_type,
  input  logic [5:0]         index,
  input  logic [63:0]        value,
  output logic               empty,
  input  logic               pop,
  output logic [63:0]        read_value,
  output logic signed [6:0]  found_index,
  output logic [6:0]         item_total,
  output logic [1:0]         status
);

  logic q_push;
  cmd_t q_in;
  logic q_full;
  logic q_pop;
  cmd_t q_out;
  logic q_valid;

  assign full = q_full;

  bale_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .req_type (req_type),
    .index    (index),
    .value    (value),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  bale_cmd_fifo u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .valid (q_valid)
  );

  bale_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd         (q_out),
    .cmd_pop     (q_pop),
    .pop         (pop),
    .empty       (empty),
    .read_value  (read_value),
    .found_index (found_index),
    .item_total  (item_total),
    .status      (status)
  );

endmodule

// File: rtl/bale_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// bale_checker
// Port-level checks on the bounded array list engine, bound to the top level.
// ============================================================================
module bale_checker import bale_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [63:0]       read_value,
  input logic signed [6:0] found_index,
  input logic [6:0]        item_total,
  input logic [1:0]        status
);

  // a result beat that is not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(read_value) && $stable(found_index)
      && $stable(item_total) && $stable(status))
    else $error("result beat changed while stalled");

  // after reset no result is waiting and the command queue is not full
  a_reset: assert property (@(posedge clk)
    rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_total: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (int'(item_total) <= CAPACITY))
    else $error("item_total above capacity");

  // a match comes only from find, which reads no word and reports ok
  a_found: assert property (@(posedge clk) disable iff (rst)
    !empty && found_index != NONE_INDEX |-> status == ST_OK && read_value == '0)
    else $error("found index on a request other than find");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    !empty && status == ST_EMPTY |-> read_value == '0 && found_index == NONE_INDEX)
    else $error("empty-store result carries data");

endmodule

bind bounded_array_list_engine bale_checker #(
  .CAPACITY (CAPACITY)
) u_bale_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .read_value  (read_value),
  .found_index (found_index),
  .item_total  (item_total),
  .status      (status)
);
